FILE: hdl/pr_pkg.sv
// Package with the shared types and constants of the PageRank edge engine.
`default_nettype none
package pr_pkg;
	localparam int MAX_NODES = 1024;
	localparam int NODE_W = 10;
	localparam int RANK_W = 32;
	localparam int FRAC_W = 16;
	localparam int DAMP_W = 16;
	localparam int ACT_W = 11;
	localparam int DEG_W = 16;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd55706;
	localparam logic [ACT_W-1:0] ACTIVE_RESET = 11'd1024;
	localparam logic [RANK_W-1:0] RANK_ONE = 32'd65536;
	localparam logic [RANK_W-1:0] NEW_RANK_RESET = 32'(65536 - 55706);
	localparam logic [RANK_W-1:0] RANK_MAX = 32'hFFFF_FFFF;

	localparam logic [CMD_W-1:0] CMD_EDGE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_END = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [NODE_W-1:0] source_node;
		logic [NODE_W-1:0] target_node;
		logic [DEG_W-1:0] source_out_degree;
	} in_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_index;
		logic [RANK_W-1:0] rank_value;
		logic pass_done;
	} out_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_DIV,
		S_WB,
		S_WALK,
		S_RESP
	} state_t;
endpackage
`default_nettype wire

FILE: hdl/pagerank_edge_engine.sv
// Top level of the PageRank edge engine: control sequencer around two rank memories.
// An edge transaction is paced by the bit-serial divider (32 steps); degree 0 updates nothing.
// A read passes load and response states; an end-of-pass walks min(active_nodes, 1024) nodes.
// One transaction is processed at a time; a finished result waits in an output register.
// After reset a clearing pass over all 1024 entries initializes both rank memories,
// during which no transaction is accepted; configuration writes are taken at any time.
`default_nettype none
module pagerank_edge_engine (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire pr_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output pr_pkg::out_t out_data,
	input wire logic cfg_we,
	input wire logic [pr_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [pr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pr_pkg::*;

	state_t state_q, state_nxt;

	logic [DAMP_W-1:0] damping_q;
	logic [ACT_W-1:0] active_q;
	logic [ACT_W-1:0] idx_q;
	logic [ACT_W-1:0] n_lim;
	logic walk_issue;
	logic walk_vld_s1;
	logic [NODE_W-1:0] walk_addr_s1;

	logic [CMD_W-1:0] cmd_q;
	logic [NODE_W-1:0] src_q;
	logic [NODE_W-1:0] dst_q;
	logic [DEG_W-1:0] deg_q;
	logic [RANK_W-1:0] prod_q;
	logic [RANK_W-1:0] acc_q;
	logic [RANK_W-1:0] rank_q;

	logic old_we, new_we;
	logic [NODE_W-1:0] old_waddr, new_waddr, old_raddr, new_raddr;
	logic [RANK_W-1:0] old_wdata, new_wdata, old_rdata, new_rdata;

	logic [RANK_W+DAMP_W-1:0] product;
	logic [RANK_W:0] sum;
	logic [RANK_W-1:0] sat_sum;
	logic [RANK_W-1:0] base;
	logic div_start, div_done;
	logic [RANK_W-1:0] quot;

	logic in_acc, out_free, out_load;
	logic out_valid_q;
	out_t out_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_RESP) && out_free;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign n_lim = (active_q > ACT_W'(MAX_NODES)) ? ACT_W'(MAX_NODES) : active_q;
	assign walk_issue = (state_q == S_WALK) && (idx_q < n_lim);
	assign base = RANK_W'(17'h10000 - {1'b0, damping_q});
	assign product = (RANK_W + DAMP_W)'(old_rdata) * (RANK_W + DAMP_W)'(damping_q);
	assign sum = {1'b0, acc_q} + {1'b0, quot};
	assign sat_sum = sum[RANK_W] ? RANK_MAX : sum[RANK_W-1:0];
	assign div_start = (state_q == S_MUL);

	pr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_old_ram (
		.clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
		.raddr(old_raddr), .rdata(old_rdata)
	);

	pr_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_new_ram (
		.clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
		.raddr(new_raddr), .rdata(new_rdata)
	);

	pr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_q),
		.divisor(deg_q), .done(div_done), .quotient(quot)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (idx_q == ACT_W'(MAX_NODES - 1)) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_data.command)
						CMD_EDGE: begin
							if (in_data.source_out_degree != '0) state_nxt = S_LOAD;
						end
						CMD_END: state_nxt = S_WALK;
						CMD_READ: state_nxt = S_LOAD;
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			S_LOAD: state_nxt = (cmd_q == CMD_EDGE) ? S_MUL : S_RESP;
			S_MUL: state_nxt = S_DIV;
			S_DIV: begin
				if (div_done) state_nxt = S_WB;
			end
			S_WB: state_nxt = S_IDLE;
			S_WALK: begin
				if (!walk_issue && !walk_vld_s1) state_nxt = S_RESP;
			end
			S_RESP: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		old_we = 1'b0;
		old_waddr = walk_addr_s1;
		old_wdata = new_rdata;
		new_we = 1'b0;
		new_waddr = idx_q[NODE_W-1:0];
		new_wdata = base;
		old_raddr = in_data.source_node;
		new_raddr = in_data.target_node;
		unique case (state_q)
			S_CLEAR: begin
				old_we = 1'b1;
				old_waddr = idx_q[NODE_W-1:0];
				old_wdata = RANK_ONE;
				new_we = 1'b1;
				new_wdata = NEW_RANK_RESET;
			end
			S_WALK: begin
				new_raddr = idx_q[NODE_W-1:0];
				new_we = walk_issue;
				old_we = walk_vld_s1;
			end
			S_WB: begin
				new_we = 1'b1;
				new_waddr = dst_q;
				new_wdata = sat_sum;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			walk_vld_s1 <= 1'b0;
			damping_q <= DAMPING_RESET;
			active_q <= ACTIVE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			walk_vld_s1 <= walk_issue;
			if (state_q == S_CLEAR || walk_issue) begin
				idx_q <= idx_q + 1'b1;
			end else if (in_acc) begin
				idx_q <= '0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DAMPING: damping_q <= cfg_wdata[DAMP_W-1:0];
					REG_ACTIVE: active_q <= cfg_wdata[ACT_W-1:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		walk_addr_s1 <= idx_q[NODE_W-1:0];
		if (in_acc) begin
			cmd_q <= in_data.command;
			src_q <= in_data.source_node;
			dst_q <= in_data.target_node;
			deg_q <= in_data.source_out_degree;
		end
		if (state_q == S_LOAD) begin
			prod_q <= product[RANK_W+DAMP_W-1:FRAC_W];
			acc_q <= new_rdata;
			rank_q <= old_rdata;
		end
		if (out_load) begin
			if (cmd_q == CMD_READ) begin
				out_q <= '{node_index: src_q, rank_value: rank_q, pass_done: 1'b0};
			end else begin
				out_q <= '{node_index: '0, rank_value: '0, pass_done: 1'b1};
			end
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("transaction accepted during the clearing pass");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("pending result changed before it was taken");

	a_walk_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_vld_s1 |-> (state_q == S_WALK))
		else $error("walk write-back outside the end-of-pass walk");
endmodule
`default_nettype wire

FILE: hdl/pr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/pr_div.sv
// Radix-2 restoring divider producing one quotient bit per cycle.
`default_nettype none
module pr_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [pr_pkg::RANK_W-1:0] dividend,
	input wire logic [pr_pkg::DEG_W-1:0] divisor,
	output logic done,
	output logic [pr_pkg::RANK_W-1:0] quotient
);
	import pr_pkg::*;

	localparam int CNT_W = $clog2(RANK_W);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RANK_W-1:0] quot_q;
	logic [DEG_W-1:0] rem_q;
	logic [DEG_W-1:0] den_q;
	logic [DEG_W:0] shifted;
	logic ge;

	assign shifted = {rem_q, quot_q[RANK_W-1]};
	assign ge = shifted >= {1'b0, den_q};
	assign quotient = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RANK_W - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DEG_W'(shifted - {1'b0, den_q}) : shifted[DEG_W-1:0];
			quot_q <= {quot_q[RANK_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire
